### rtl/core/sgdcb_pkg.sv
// Package for the scatter-gather descriptor chain builder.
// Holds constants, controller states and the command and status structs.
// No dependencies.
`default_nettype none

package sgdcb_pkg;

    localparam int CHUNK_W        = 24;
    localparam int MAX_GROUP      = 1024;
    localparam int MAX_SEG_CHUNKS = 64;
    localparam int DESC_SHIFT     = 5;
    localparam int GROUP_W        = 11;
    localparam int CFG_IDX_W      = 2;

    localparam logic [31:0] CHUNK_BYTES   = 32'(1 << CHUNK_W);
    localparam logic [31:0] SEG_LEN_LIMIT = 32'(MAX_SEG_CHUNKS * (1 << CHUNK_W));

    localparam logic [CFG_IDX_W-1:0] REG_PCIE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd2;

    localparam logic [GROUP_W-1:0] GROUP_RESET = 11'(MAX_GROUP);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } sgdcb_state_t;

    typedef struct packed {
        logic load_seg;
        logic emit_desc;
        logic emit_err;
    } sgdcb_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic in_err;
        logic final_chunk;
        logic out_free;
    } sgdcb_status_t;

endpackage

`default_nettype wire

### rtl/core/sg_descriptor_chain_builder.sv
// Top level of the scatter-gather descriptor chain builder.
// Instantiates sgdcb_ctrl and sgdcb_datapath; depends on sgdcb_pkg.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   seg_addr, seg_len, last_segment
//   out      out_valid / out_stall axi_addr .. error
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A segment is taken while the controller is idle, then one descriptor is
// emitted per chunk while the output is free; a zero-length segment emits
// nothing; an error segment emits one error item. Reset returns the
// configuration to its defaults and closes any open list. A stalled output
// holds the controller in place; input is stalled until the segment is done.
`default_nettype none

module sg_descriptor_chain_builder (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [31:0] seg_addr,
    input  wire  [31:0] seg_len,
    input  wire         last_segment,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [31:0] axi_addr,
    output logic [63:0] dev_addr,
    output logic [23:0] len_field,
    output logic        irq_flag,
    output logic        chain_flag,
    output logic [9:0]  slot,
    output logic [31:0] next_desc_addr,
    output logic        run_end,
    output logic        error
);

    sgdcb_pkg::sgdcb_cmd_t    cmd;
    sgdcb_pkg::sgdcb_status_t status;

    assign cfg_ready = 1'b1;

    sgdcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sgdcb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .seg_addr       (seg_addr),
        .seg_len        (seg_len),
        .last_segment   (last_segment),
        .cmd            (cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .axi_addr       (axi_addr),
        .dev_addr       (dev_addr),
        .len_field      (len_field),
        .irq_flag       (irq_flag),
        .chain_flag     (chain_flag),
        .slot           (slot),
        .next_desc_addr (next_desc_addr),
        .run_end        (run_end),
        .error          (error)
    );

endmodule

`default_nettype wire

### rtl/core/sgdcb_ctrl.sv
// Controller state machine of the descriptor chain builder.
// Sequences segment load, descriptor emission and error results.
// Depends on sgdcb_pkg.
`default_nettype none

module sgdcb_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  sgdcb_pkg::sgdcb_status_t status,
    output sgdcb_pkg::sgdcb_cmd_t    cmd
);

    sgdcb_pkg::sgdcb_state_t state_reg;
    sgdcb_pkg::sgdcb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgdcb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_stall      = 1'b1;
        case (state_reg)
            sgdcb_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_seg = 1'b1;
                    if (status.in_zero)
                    begin
                        state_next = sgdcb_pkg::ST_IDLE;
                    end
                    else if (status.in_err)
                    begin
                        state_next = sgdcb_pkg::ST_ERR;
                    end
                    else
                    begin
                        state_next = sgdcb_pkg::ST_RUN;
                    end
                end
            end
            sgdcb_pkg::ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_desc = 1'b1;
                    if (status.final_chunk)
                    begin
                        state_next = sgdcb_pkg::ST_IDLE;
                    end
                end
            end
            sgdcb_pkg::ST_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = sgdcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgdcb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/sgdcb_datapath.sv
// Datapath of the descriptor chain builder: configuration, segment and
// cursor registers, chunk arithmetic and the output register.
// Depends on sgdcb_pkg.
`default_nettype none

module sgdcb_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire  [1:0]            cfg_index,
    input  wire  [63:0]           cfg_data,
    input  wire  [31:0]           seg_addr,
    input  wire  [31:0]           seg_len,
    input  wire                   last_segment,
    input  sgdcb_pkg::sgdcb_cmd_t    cmd,
    output sgdcb_pkg::sgdcb_status_t status,
    input  wire                   out_stall,
    output logic                  out_valid,
    output logic [31:0]           axi_addr,
    output logic [63:0]           dev_addr,
    output logic [23:0]           len_field,
    output logic                  irq_flag,
    output logic                  chain_flag,
    output logic [9:0]            slot,
    output logic [31:0]           next_desc_addr,
    output logic                  run_end,
    output logic                  error
);

    logic [63:0] pcie_start_reg;
    logic [31:0] ring_base_reg;
    logic [10:0] group_size_reg;

    logic [31:0] addr_reg;
    logic [31:0] len_reg;
    logic        last_reg;
    logic [63:0] cursor_reg;
    logic [9:0]  slot_reg;
    logic        list_open_reg;

    logic        out_valid_reg;
    logic [31:0] axi_addr_reg;
    logic [63:0] dev_addr_reg;
    logic [23:0] len_field_reg;
    logic        irq_reg;
    logic        chain_reg;
    logic [9:0]  slot_out_reg;
    logic [31:0] next_desc_reg;
    logic        run_end_reg;
    logic        error_reg;

    logic        final_chunk;
    logic [31:0] chunk;
    logic [10:0] slot_p1;
    logic [10:0] group_eff;
    logic        irq;
    logic        close_list;
    logic        out_free;

    always_comb
    begin
        if (group_size_reg == 11'd0)
        begin
            group_eff = 11'd1;
        end
        else if (group_size_reg > sgdcb_pkg::GROUP_RESET)
        begin
            group_eff = sgdcb_pkg::GROUP_RESET;
        end
        else
        begin
            group_eff = group_size_reg;
        end
    end

    assign final_chunk = (len_reg <= sgdcb_pkg::CHUNK_BYTES);
    assign chunk       = final_chunk ? len_reg : sgdcb_pkg::CHUNK_BYTES;
    assign slot_p1     = {1'b0, slot_reg} + 11'd1;
    assign irq         = (slot_p1 >= group_eff) || (final_chunk && last_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign close_list  = (cmd.load_seg && (seg_len == 32'd0) && last_segment)
                      || (cmd.emit_err && last_reg)
                      || (cmd.emit_desc && final_chunk && last_reg);

    assign status.in_zero     = (seg_len == 32'd0);
    assign status.in_err      = (seg_len > sgdcb_pkg::SEG_LEN_LIMIT);
    assign status.final_chunk = final_chunk;
    assign status.out_free    = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcie_start_reg <= '0;
            ring_base_reg  <= '0;
            group_size_reg <= sgdcb_pkg::GROUP_RESET;
            cursor_reg     <= '0;
            slot_reg       <= '0;
            list_open_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sgdcb_pkg::REG_PCIE_START: pcie_start_reg <= cfg_data;
                    sgdcb_pkg::REG_RING_BASE:  ring_base_reg  <= cfg_data[31:0];
                    sgdcb_pkg::REG_GROUP_SIZE: group_size_reg <= cfg_data[10:0];
                    default:                   ;
                endcase
            end

            if (cmd.load_seg && !list_open_reg)
            begin
                cursor_reg    <= pcie_start_reg;
                slot_reg      <= '0;
                list_open_reg <= 1'b1;
            end
            if (cmd.emit_desc)
            begin
                cursor_reg <= cursor_reg + 64'(chunk);
                slot_reg   <= irq ? 10'd0 : slot_p1[9:0];
            end
            if (close_list)
            begin
                list_open_reg <= 1'b0;
            end

            if (cmd.emit_desc || cmd.emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seg)
        begin
            addr_reg <= seg_addr;
            len_reg  <= seg_len;
            last_reg <= last_segment;
        end
        else if (cmd.emit_desc)
        begin
            addr_reg <= addr_reg + chunk;
            len_reg  <= len_reg - chunk;
        end

        if (cmd.emit_desc)
        begin
            axi_addr_reg  <= addr_reg;
            dev_addr_reg  <= cursor_reg;
            len_field_reg <= final_chunk && (len_reg != sgdcb_pkg::CHUNK_BYTES)
                             ? len_reg[23:0] : 24'd0;
            irq_reg       <= irq;
            chain_reg     <= !irq;
            slot_out_reg  <= slot_reg;
            next_desc_reg <= ring_base_reg + (32'(slot_p1) << sgdcb_pkg::DESC_SHIFT);
            run_end_reg   <= final_chunk;
            error_reg     <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            axi_addr_reg  <= '0;
            dev_addr_reg  <= '0;
            len_field_reg <= '0;
            irq_reg       <= 1'b0;
            chain_reg     <= 1'b0;
            slot_out_reg  <= '0;
            next_desc_reg <= '0;
            run_end_reg   <= 1'b1;
            error_reg     <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign axi_addr       = axi_addr_reg;
    assign dev_addr       = dev_addr_reg;
    assign len_field      = len_field_reg;
    assign irq_flag       = irq_reg;
    assign chain_flag     = chain_reg;
    assign slot           = slot_out_reg;
    assign next_desc_addr = next_desc_reg;
    assign run_end        = run_end_reg;
    assign error          = error_reg;

    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_desc |-> (len_reg != 32'd0))
        else $error("Descriptor emitted with no bytes left in the segment.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !error_reg) |-> (irq_reg != chain_reg))
        else $error("Descriptor has interrupt and chaining in the same state.");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> (run_end_reg && !irq_reg && !chain_reg))
        else $error("Error item is not a lone closing item.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(cmd.emit_desc || cmd.emit_err))
        else $error("Output register loaded while its item is stalled.");

endmodule

`default_nettype wire

### tb/tb_sg_descriptor_chain_builder.sv
`timescale 1ns / 1ps
// Self-checking testbench for sg_descriptor_chain_builder: directed and random segments,
// random input gaps and output stalls, every descriptor checked against a built-in predictor.
// Depends on sgdcb_pkg and the sg_descriptor_chain_builder RTL only.

module tb_sg_descriptor_chain_builder;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [31:0] axi_addr;
        logic [63:0] dev_addr;
        logic [23:0] len_field;
        logic        irq;
        logic        chain;
        logic [9:0]  slot;
        logic [31:0] next_addr;
        logic        run_end;
        logic        error;
    } desc_t;

    class sg_chain_tracker;
        logic [63:0] pcie_start;
        logic [31:0] ring_base;
        logic [10:0] group_size;
        logic [63:0] dev_cursor;
        int unsigned slot_count;
        bit          list_open;
        desc_t       pending_descs[$];
        int          mismatches;
        int          checked;

        function new();
            pcie_start = '0;
            ring_base  = '0;
            group_size = sgdcb_pkg::GROUP_RESET;
            dev_cursor = '0;
            slot_count = 0;
            list_open  = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                sgdcb_pkg::REG_PCIE_START: pcie_start = data;
                sgdcb_pkg::REG_RING_BASE:  ring_base = data[31:0];
                sgdcb_pkg::REG_GROUP_SIZE: group_size = data[10:0];
                default: ;
            endcase
        endfunction

        function void take_segment(logic [31:0] addr, logic [31:0] len, logic last);
            logic [31:0] cur;
            logic [31:0] left;
            logic [31:0] c;
            logic [63:0] nchunks;
            int unsigned g;
            bit          fin;
            bit          irq;
            desc_t       d;
            if (!list_open)
            begin
                dev_cursor = pcie_start;
                slot_count = 0;
                list_open = 1'b1;
            end
            if (len == 0)
            begin
                if (last)
                    list_open = 1'b0;
                return;
            end
            nchunks = (64'(len) + 64'(sgdcb_pkg::CHUNK_BYTES) - 64'd1)
                      / 64'(sgdcb_pkg::CHUNK_BYTES);
            if (nchunks > 64'(sgdcb_pkg::MAX_SEG_CHUNKS))
            begin
                d = '{default: '0};
                d.run_end = 1'b1;
                d.error = 1'b1;
                pending_descs.push_back(d);
                if (last)
                    list_open = 1'b0;
                return;
            end
            cur = addr;
            left = len;
            while (left != 0)
            begin
                g = group_size;
                if (g == 0)
                    g = 1;
                if (g > sgdcb_pkg::MAX_GROUP)
                    g = sgdcb_pkg::MAX_GROUP;
                c = (left >= sgdcb_pkg::CHUNK_BYTES) ? sgdcb_pkg::CHUNK_BYTES : left;
                fin = (left == c);
                irq = (slot_count + 1 >= g) || (fin && last);
                d.axi_addr  = cur;
                d.dev_addr  = dev_cursor;
                d.len_field = (c == sgdcb_pkg::CHUNK_BYTES) ? 24'd0 : c[23:0];
                d.irq       = irq;
                d.chain     = !irq;
                d.slot      = 10'(slot_count);
                d.next_addr = ring_base + 32'((slot_count + 1) << sgdcb_pkg::DESC_SHIFT);
                d.run_end   = fin;
                d.error     = 1'b0;
                pending_descs.push_back(d);
                cur = cur + c;
                dev_cursor = dev_cursor + 64'(c);
                left = left - c;
                slot_count = irq ? 0 : slot_count + 1;
            end
            if (last)
                list_open = 1'b0;
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                flag_mismatch($sformatf("descriptor %0d field %s got %h expected %h",
                                        checked, name, got, want));
        endtask

        task match_desc(desc_t got);
            desc_t want;
            if (pending_descs.size() == 0)
            begin
                flag_mismatch("descriptor arrived with none pending");
                return;
            end
            want = pending_descs.pop_front();
            compare_field("axi_addr", got.axi_addr, want.axi_addr);
            compare_field("dev_addr", got.dev_addr, want.dev_addr);
            compare_field("len_field", got.len_field, want.len_field);
            compare_field("irq_flag", got.irq, want.irq);
            compare_field("chain_flag", got.chain, want.chain);
            compare_field("slot", got.slot, want.slot);
            compare_field("next_desc_addr", got.next_addr, want.next_addr);
            compare_field("run_end", got.run_end, want.run_end);
            compare_field("error", got.error, want.error);
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] seg_addr;
    logic [31:0] seg_len;
    logic        last_segment;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] axi_addr;
    logic [63:0] dev_addr;
    logic [23:0] len_field;
    logic        irq_flag;
    logic        chain_flag;
    logic [9:0]  slot;
    logic [31:0] next_desc_addr;
    logic        run_end;
    logic        error;

    bit              steady = 1'b0;
    bit              hold_req = 1'b0;
    int              cycles = 0;
    desc_t           seen;
    sg_chain_tracker chain = new();

    sg_descriptor_chain_builder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .seg_addr       (seg_addr),
        .seg_len        (seg_len),
        .last_segment   (last_segment),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axi_addr       (axi_addr),
        .dev_addr       (dev_addr),
        .len_field      (len_field),
        .irq_flag       (irq_flag),
        .chain_flag     (chain_flag),
        .slot           (slot),
        .next_desc_addr (next_desc_addr),
        .run_end        (run_end),
        .error          (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                chain.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                chain.take_segment(seg_addr, seg_len, last_segment);
            if (out_valid && !out_stall)
            begin
                seen = '{axi_addr, dev_addr, len_field, irq_flag, chain_flag, slot,
                         next_desc_addr, run_end, error};
                chain.match_desc(seen);
            end
        end
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d descriptors pending",
                     cycles, chain.pending_descs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : receiver
        int unsigned wait_cycles;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                wait_cycles = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                wait_cycles = steady ? 0 : $urandom_range(0, 12);
            @(negedge clk);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid && !hold_req);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_segment(input logic [31:0] addr, input logic [31:0] len,
                                input logic last);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        seg_addr <= addr;
        seg_len <= len;
        last_segment <= last;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_chain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chain.pending_descs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(1, 256);
        else if (r < 55)
            return $urandom_range(1, 32'h00FF_FFFF);
        else if (r < 70)
            return $urandom_range(1, 32'h0400_0000);
        else if (r < 78)
            return 32'($urandom_range(1, 4)) << sgdcb_pkg::CHUNK_W;
        else if (r < 84)
            return 32'd0;
        else if (r < 90)
            return $urandom_range(32'h0400_0001, 32'h4000_0000);
        else
            return $urandom;
    endfunction

    task automatic random_phase(input int count, input bit long_hold);
        logic [63:0] data;
        logic [10:0] g;
        case ($urandom_range(0, 3))
            0: g = 11'($urandom_range(1, 4));
            1: g = 11'($urandom_range(1, 40));
            2: g = 11'($urandom_range(0, 2047));
            default: g = sgdcb_pkg::GROUP_RESET;
        endcase
        write_reg(sgdcb_pkg::REG_PCIE_START, {$urandom, $urandom});
        write_reg(sgdcb_pkg::REG_RING_BASE, {$urandom, $urandom});
        data = {$urandom, $urandom};
        data[10:0] = g;
        write_reg(sgdcb_pkg::REG_GROUP_SIZE, data);
        if (long_hold)
            hold_req = 1'b1;
        for (int i = 0; i < count; i++)
            push_segment($urandom, pick_len(), $urandom_range(0, 7) == 0);
        drain_chain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sgdcb_pkg::REG_PCIE_START;
        cfg_data = '0;
        in_valid = 1'b0;
        seg_addr = '0;
        seg_len = '0;
        last_segment = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        push_segment(32'h0000_0000, 32'd1, 1'b0);
        push_segment(32'hFF80_0000, 32'h0100_0001, 1'b0);
        push_segment(32'h1234_5000, sgdcb_pkg::CHUNK_BYTES, 1'b0);
        push_segment(32'hDEAD_BEEF, 32'd0, 1'b0);
        push_segment(32'h0000_0000, 32'd0, 1'b1);
        push_segment(32'h8000_0000, sgdcb_pkg::SEG_LEN_LIMIT, 1'b1);
        push_segment(32'hFFFF_FFFF, sgdcb_pkg::SEG_LEN_LIMIT + 32'd1, 1'b0);
        push_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain_chain();

        write_reg(sgdcb_pkg::REG_PCIE_START, 64'hFFFF_FFFF_FF00_0000);
        write_reg(sgdcb_pkg::REG_RING_BASE, 64'hFFFF_FFFF_FFFF_FFE0);
        write_reg(sgdcb_pkg::REG_GROUP_SIZE, 64'd1);
        push_segment(32'h0000_0000, 32'h0200_0000, 1'b1);
        drain_chain();

        write_reg(sgdcb_pkg::REG_GROUP_SIZE, 64'd0);
        write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(sgdcb_pkg::REG_PCIE_START, 64'd0);
        write_reg(sgdcb_pkg::REG_RING_BASE, 64'd0);
        push_segment(32'h0000_0010, 32'h0000_0FFF, 1'b0);
        push_segment(32'h0000_0020, 32'h00FF_FFFF, 1'b1);
        drain_chain();

        write_reg(sgdcb_pkg::REG_GROUP_SIZE, 64'd2047);
        write_reg(sgdcb_pkg::REG_PCIE_START, 64'h0000_0001_0000_0000);
        for (int i = 0; i < 4; i++)
            push_segment($urandom, 32'd16, 1'b0);
        drain_chain();
        write_reg(sgdcb_pkg::REG_PCIE_START, 64'h5555_AAAA_5555_AAAA);
        write_reg(sgdcb_pkg::REG_GROUP_SIZE, 64'd3);
        push_segment($urandom, 32'd8, 1'b0);
        push_segment($urandom, 32'd8, 1'b1);
        drain_chain();

        random_phase(40, 1'b0);
        random_phase(40, 1'b1);
        steady = 1'b1;
        random_phase(30, 1'b0);
        steady = 1'b0;

        write_reg(sgdcb_pkg::REG_GROUP_SIZE, 64'(sgdcb_pkg::GROUP_RESET));
        write_reg(sgdcb_pkg::REG_RING_BASE, {$urandom, $urandom});
        for (int i = 0; i < 17; i++)
            push_segment($urandom,
                         $urandom_range(32'h3F00_0001, sgdcb_pkg::SEG_LEN_LIMIT),
                         i == 16);
        drain_chain();

        random_phase(40, 1'b0);
        random_phase(40, 1'b0);

        if (chain.pending_descs.size() != 0)
            chain.flag_mismatch("descriptors still pending at the end");
        if (chain.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sg_descriptor_chain_builder.f
rtl/core/sgdcb_pkg.sv
rtl/core/sgdcb_ctrl.sv
rtl/core/sgdcb_datapath.sv
rtl/core/sg_descriptor_chain_builder.sv
tb/tb_sg_descriptor_chain_builder.sv
